// ----- src/quadrature_encoder_speed_filter_unit_defines.svh -----
// Assertion macros for the quadrature encoder speed filter.
`ifndef QUADRATURE_ENCODER_SPEED_FILTER_UNIT_DEFINES_SVH
`define QUADRATURE_ENCODER_SPEED_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked only out of reset.
`define QESF_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("qesf: assertion failed");
// Checked at every edge, reset included.
`define QESF_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("qesf: assertion failed");
`else
`define QESF_ASSERT(lbl, clk_s, rst_s, prop)
`define QESF_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

// ----- src/qesf_pkg.sv -----
// Types, constants and helper functions of the quadrature encoder speed filter.
package qesf_pkg;

  localparam int CNT_W    = 16;
  localparam int WGT_W    = 8;
  localparam int WHEELS   = 2;
  localparam int NUM_WGT  = 4;
  localparam int PROD_W   = CNT_W + WGT_W + 1;

  localparam logic [WGT_W-1:0] WGT_NEWEST_RST = 8'd205;
  localparam logic [WGT_W-1:0] WGT_SECOND_RST = 8'd26;
  localparam logic [WGT_W-1:0] WGT_THIRD_RST  = 8'd15;
  localparam logic [WGT_W-1:0] WGT_OLDEST_RST = 8'd10;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    REG_WEIGHT_NEWEST = 2'd0,
    REG_WEIGHT_SECOND = 2'd1,
    REG_WEIGHT_THIRD  = 2'd2,
    REG_WEIGHT_OLDEST = 2'd3
  } qesf_reg_t;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } qesf_op_t;

  // One wheel's slice of in_tdata, a_flag in the lowest bit.
  typedef struct packed {
    logic b_level;
    logic a_level;
    logic b_flag;
    logic a_flag;
  } qesf_pins_t;

  typedef logic signed [CNT_W-1:0] qesf_cnt_t;

  // x2 decode step with saturation; A edge wins over B edge.
  function automatic qesf_cnt_t edge_step(qesf_cnt_t cnt, qesf_pins_t pins);
    logic up;
    logic dn;
    qesf_cnt_t res;
    up  = 1'b0;
    dn  = 1'b0;
    res = cnt;
    if (pins.a_flag) begin
      up = pins.b_level;
      dn = !pins.b_level;
    end else if (pins.b_flag) begin
      up = !pins.a_level;
      dn = pins.a_level;
    end
    if (up && cnt != CNT_MAX) begin
      res = cnt + 16'sd1;
    end else if (dn && cnt != CNT_MIN) begin
      res = cnt - 16'sd1;
    end
    return res;
  endfunction

  function automatic qesf_cnt_t sat_negate(qesf_cnt_t v);
    return (v == CNT_MIN) ? CNT_MAX : -v;
  endfunction

endpackage

// ----- src/quadrature_encoder_speed_filter_unit.sv -----
// Two-wheel quadrature encoder counter with weighted moving-average speed filter.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  in_     | in  | in_tvalid / in_tready | tuser: op; tdata: left then right pins
//  out_    | out | out_tvalid/out_tready | tdata: left/right speed, left/right raw
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index (weight), cfg_data (Q0.8)
//
// One beat per cycle in while the output is not stalled; a tick's result reaches
// out_tvalid through the history shift, then TAPS products, then sum, then
// round and saturate into the output register.
// rst_n is synchronous: counts, history and valids clear, weights reload.
// A stalled output holds the whole pipeline, in_tready included.
// cfg_ready is always high.
`include "quadrature_encoder_speed_filter_unit_defines.svh"

module quadrature_encoder_speed_filter_unit
  import qesf_pkg::*;
#(
  parameter int TAPS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] left_a_flag [1] left_b_flag [2] left_a_level [3] left_b_level
  // [4] right_a_flag [5] right_b_flag [6] right_a_level [7] right_b_level
  input  logic [7:0]  in_tdata,
  // [0] op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] left_speed [31:16] right_speed [47:32] left_raw [63:48] right_raw
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SUM_W = PROD_W + $clog2(TAPS);
  localparam int Q_W   = SUM_W - WGT_W;

  logic en;
  logic accept;
  logic is_tick;

  logic [WGT_W-1:0] weight_r [NUM_WGT];

  qesf_cnt_t count_r   [WHEELS];
  qesf_cnt_t count_nxt [WHEELS];
  qesf_cnt_t raw       [WHEELS];
  qesf_cnt_t hist_r    [WHEELS][TAPS];

  logic                     s1_vld_r;
  logic                     s2_vld_r;
  logic                     s3_vld_r;
  logic                     out_vld_r;
  logic signed [PROD_W-1:0] prod_r  [WHEELS][TAPS];
  qesf_cnt_t                s2_raw_r [WHEELS];
  logic signed [SUM_W-1:0]  sum_nxt [WHEELS];
  logic signed [SUM_W-1:0]  sum_r   [WHEELS];
  qesf_cnt_t                s3_raw_r [WHEELS];
  qesf_cnt_t                spd_nxt [WHEELS];
  logic [63:0]              out_data_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign is_tick   = (qesf_op_t'(in_tuser) == OP_TICK);
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r[0] <= WGT_NEWEST_RST;
      weight_r[1] <= WGT_SECOND_RST;
      weight_r[2] <= WGT_THIRD_RST;
      weight_r[3] <= WGT_OLDEST_RST;
    end else if (cfg_valid) begin
      unique case (qesf_reg_t'(cfg_index))
        REG_WEIGHT_NEWEST: weight_r[0] <= cfg_data;
        REG_WEIGHT_SECOND: weight_r[1] <= cfg_data;
        REG_WEIGHT_THIRD:  weight_r[2] <= cfg_data;
        REG_WEIGHT_OLDEST: weight_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      count_nxt[w] = edge_step(count_r[w], qesf_pins_t'(in_tdata[4*w +: 4]));
    end
    raw[0] = count_r[0];
    raw[1] = sat_negate(count_r[1]);
  end

  // counters and history shift line; tap 0 is the newest sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < WHEELS; w++) begin
        count_r[w] <= '0;
        for (int i = 0; i < TAPS; i++) begin
          hist_r[w][i] <= '0;
        end
      end
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= accept && is_tick;
      if (accept) begin
        for (int w = 0; w < WHEELS; w++) begin
          if (is_tick) begin
            count_r[w]   <= '0;
            hist_r[w][0] <= raw[w];
            for (int i = 1; i < TAPS; i++) begin
              hist_r[w][i] <= hist_r[w][i-1];
            end
          end else begin
            count_r[w] <= count_nxt[w];
          end
        end
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        s2_raw_r[w] <= hist_r[w][0];
        for (int i = 0; i < TAPS; i++) begin
          prod_r[w][i] <= PROD_W'($signed(hist_r[w][i]) * $signed({1'b0, weight_r[i]}));
        end
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      sum_nxt[w] = '0;
      for (int i = 0; i < TAPS; i++) begin
        sum_nxt[w] = sum_nxt[w] + SUM_W'(prod_r[w][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        sum_r[w]    <= sum_nxt[w];
        s3_raw_r[w] <= s2_raw_r[w];
      end
    end
  end

  // divide by 256 toward zero, then clamp to 16 bits
  always_comb begin
    logic signed [SUM_W-1:0] biased;
    logic signed [Q_W-1:0]   q;
    for (int w = 0; w < WHEELS; w++) begin
      biased = sum_r[w] + {{(SUM_W-WGT_W){1'b0}}, {WGT_W{sum_r[w][SUM_W-1]}}};
      q      = biased[SUM_W-1:WGT_W];
      if ((&q[Q_W-1:CNT_W-1]) || !(|q[Q_W-1:CNT_W-1])) begin
        spd_nxt[w] = q[CNT_W-1:0];
      end else begin
        spd_nxt[w] = q[Q_W-1] ? CNT_MIN : CNT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {s3_raw_r[1], s3_raw_r[0], spd_nxt[1], spd_nxt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `QESF_ASSERT(a_idle_edge_holds, clk, rst_n, in_tvalid && in_tready && !in_tuser && in_tdata[1:0] == 2'b00 && in_tdata[5:4] == 2'b00 |=> $stable(count_r[0]) && $stable(count_r[1]))
  `QESF_ASSERT(a_tick_clears, clk, rst_n, in_tvalid && in_tready && in_tuser |=> count_r[0] == 16'sd0 && count_r[1] == 16'sd0)
  `QESF_ASSERT(a_tick_latches, clk, rst_n, in_tvalid && in_tready && in_tuser |=> hist_r[0][0] == $past(raw[0]) && hist_r[1][0] == $past(raw[1]))
  `QESF_ASSERT_ALWAYS(a_reset_no_out, clk, !rst_n |=> !out_tvalid && !s3_vld_r)

endmodule
